>>> rtl/core/lbf_pkg.sv
// Shared constants and types for the lidar beam background filter.
`default_nettype none
package lbf_pkg;
	localparam int BEAMS     = 1024;
	localparam int ADDR_W    = $clog2(BEAMS);
	localparam int INDEX_W   = 10;
	localparam int RANGE_W   = 16;
	localparam int CNT_W     = 8;
	localparam int VAR_W     = 17;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int COUNT_MAX = 255;
	localparam int FAR_MM    = 29800;
	localparam int NEAR_MM   = 100;
	localparam int RECIP_SH  = 25;
	localparam int RECIP_W   = RECIP_SH + 1;

	typedef enum logic [1:0] {
		MODE_LEARN_MASK = 2'd0,
		MODE_LEARN_BG   = 2'd1,
		MODE_CLASSIFY   = 2'd2,
		MODE_UNUSED     = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_RANGE_MIN = 3'd1,
		REG_RANGE_MAX = 3'd2,
		REG_LEARN_TOL = 3'd3,
		REG_MASK_TOL  = 3'd4,
		REG_BG_TOL    = 3'd5,
		REG_USE_BG    = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               mask_present;
		logic [RANGE_W-1:0] mask_range;
		logic               bg_present;
		logic [RANGE_W-1:0] bg_average;
		logic [CNT_W-1:0]   bg_count;
		logic [VAR_W-1:0]   bg_variation;
	} beam_entry_t;
endpackage
`default_nettype wire

>>> rtl/core/lbf_beam_mem.sv
// Per-beam state memory, one write port and one registered read port.
`default_nettype none
module lbf_beam_mem (
	input  wire                          clk,
	input  wire                          wr_en,
	input  wire [lbf_pkg::ADDR_W-1:0]    wr_addr,
	input  lbf_pkg::beam_entry_t         wr_data,
	input  wire                          rd_en,
	input  wire [lbf_pkg::ADDR_W-1:0]    rd_addr,
	output lbf_pkg::beam_entry_t         rd_data
);
	import lbf_pkg::*;

	beam_entry_t mem [BEAMS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/lidar_beam_background_filter.sv
// Top level: per-beam mask/background learning and foreground classification.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | beam_index, range_mm
//   out     | output    | out_valid / out_stall| index_out, range_out, flags
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// Four register stages (memory read, reciprocal multiply, update, output); one
// item per cycle unless out_stall or a beam hazard (below) stalls the input;
// results leave in input order through out_valid / out_stall.
// A new sample on a beam that an in-flight learning sample will rewrite waits
// until that write is done.
// After reset a clearing pass runs through all BEAMS beam memory entries;
// in_stall stays high during it.
// out_stall holds the output register; stages behind it keep filling bubbles.
`default_nettype none
module lidar_beam_background_filter (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [lbf_pkg::INDEX_W-1:0]       beam_index,
	input  wire [lbf_pkg::RANGE_W-1:0]       range_mm,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [lbf_pkg::INDEX_W-1:0]      index_out,
	output logic [lbf_pkg::RANGE_W-1:0]      range_out,
	output logic                             sample_valid,
	output logic                             in_mask,
	output logic                             in_background,
	output logic                             foreground,
	input  wire                              cfg_we,
	input  wire [lbf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [lbf_pkg::CFG_W-1:0]         cfg_data
);
	import lbf_pkg::*;

	// configuration
	mode_t              mode_q;
	logic [RANGE_W-1:0] rmin_q, rmax_q, ltol_q, mtol_q, btol_q;
	logic               use_bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CLASSIFY;
			rmin_q   <= '0;
			rmax_q   <= 16'hFFFF;
			ltol_q   <= RANGE_W'(100);
			mtol_q   <= RANGE_W'(100);
			btol_q   <= RANGE_W'(100);
			use_bg_q <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:      mode_q   <= mode_t'(cfg_data[1:0]);
				REG_RANGE_MIN: rmin_q   <= cfg_data;
				REG_RANGE_MAX: rmax_q   <= cfg_data;
				REG_LEARN_TOL: ltol_q   <= cfg_data;
				REG_MASK_TOL:  mtol_q   <= cfg_data;
				REG_BG_TOL:    btol_q   <= cfg_data;
				REG_USE_BG:    use_bg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// reciprocal table: ceil(2^RECIP_SH / (c + 1))
	logic [RECIP_W-1:0] recip_tab [2**CNT_W];
	for (genvar gi = 0; gi < 2**CNT_W; gi++) begin : g_recip
		localparam logic [RECIP_W-1:0] RV = RECIP_W'((2**RECIP_SH + gi) / (gi + 1));
		assign recip_tab[gi] = RV;
	end

	// clearing pass
	logic              clr_active_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(BEAMS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// pipeline registers
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [INDEX_W-1:0] beam_s1, beam_s2, beam_s3, beam_s4;
	logic [RANGE_W-1:0] range_s1, range_s2, range_s3, range_s4;
	logic               valid_s2, valid_s3, valid_s4;
	logic               im_s2, im_s3, im_s4;
	logic               ib_s2, ib_s3, ib_s4;
	logic               fg_s2, fg_s3, fg_s4;
	logic               wm_s2, wm_s3;
	logic               wi_s2, wi_s3;
	logic               wu_s2, wu_s3;
	logic               neg_s2, neg_s3;
	beam_entry_t        ent_s2, ent_s3;
	logic [VAR_W-1:0]   mq_s2;
	logic [RECIP_W-1:0] recip_s2;
	logic [VAR_W+RECIP_W-1:0] prod_s3;

	// rdyN: stage N+1 register may load; en1: stage 1 register may load
	logic rdy1, rdy2, rdy3, en1, accept, hazard;

	assign rdy3 = !v_s4 || !out_stall;
	assign rdy2 = !v_s3 || rdy3;
	assign rdy1 = !v_s2 || rdy2;
	assign en1  = !v_s1 || rdy1;

	assign hazard = (v_s1 && beam_s1 == beam_index && mode_q != MODE_CLASSIFY)
		|| (v_s2 && (wm_s2 || wi_s2 || wu_s2) && beam_s2 == beam_index)
		|| (v_s3 && (wm_s3 || wi_s3 || wu_s3) && beam_s3 == beam_index);
	assign in_stall = clr_active_q || !en1 || hazard;
	assign accept   = in_valid && !in_stall;

	logic [31:0]       beam_ext;
	logic [ADDR_W-1:0] rd_addr;
	assign beam_ext = 32'(beam_index);
	assign rd_addr  = beam_ext[ADDR_W-1:0];

	// memory
	beam_entry_t       rd_ent, upd_ent, wr_ent;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       beam3_ext;
	assign beam3_ext = 32'(beam_s3);

	always_comb begin
		if (clr_active_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_ent  = '0;
		end else begin
			wr_en   = v_s3 && rdy3 && (wm_s3 || wi_s3 || wu_s3);
			wr_addr = beam3_ext[ADDR_W-1:0];
			wr_ent  = upd_ent;
		end
	end

	lbf_beam_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (en1),
		.rd_addr (rd_addr),
		.rd_data (rd_ent)
	);

	// stage 1: decisions and classification
	logic               valid1, inside1, far1, near1, neg1;
	logic [RANGE_W-1:0] mag1;
	logic [8:0]         n1;
	logic [VAR_W-1:0]   mq1;
	logic               lm1, li1, lu1, mm1, bm1, cls1, im1, ib1, fg1;
	logic [17:0]        vs1, vabs1;
	logic [18:0]        hi1;
	logic signed [19:0] lo1;
	logic signed [17:0] mlo1;

	always_comb begin
		valid1  = range_s1 > rmin_q && range_s1 < rmax_q;
		inside1 = 32'(beam_s1) < BEAMS;
		far1    = range_s1 > RANGE_W'(FAR_MM);
		near1   = range_s1 < RANGE_W'(NEAR_MM);
		neg1    = range_s1 < rd_ent.bg_average;
		mag1    = neg1 ? rd_ent.bg_average - range_s1 : range_s1 - rd_ent.bg_average;
		n1      = {1'b0, rd_ent.bg_count} + 9'd1;
		// floor of a negative quotient is minus the ceiling of the magnitude
		mq1     = neg1 ? VAR_W'(mag1) + VAR_W'(n1) - VAR_W'(1) : VAR_W'(mag1);
		lm1 = mode_q == MODE_LEARN_MASK && valid1 && inside1
			&& (!rd_ent.mask_present || rd_ent.mask_range > range_s1);
		li1 = mode_q == MODE_LEARN_BG && valid1 && inside1 && !rd_ent.bg_present
			&& range_s1 < RANGE_W'(FAR_MM) && !near1 && range_s1 != RANGE_W'(NEAR_MM);
		lu1 = mode_q == MODE_LEARN_BG && valid1 && inside1 && rd_ent.bg_present
			&& !far1 && !near1 && !(mag1 > ltol_q);
		mlo1 = $signed({2'b00, rd_ent.mask_range}) - $signed({2'b00, mtol_q});
		mm1  = rd_ent.mask_present && (far1 || mlo1 < $signed({2'b00, range_s1}));
		vs1   = {rd_ent.bg_variation[VAR_W-1], rd_ent.bg_variation};
		vabs1 = vs1[17] ? 18'(-vs1) : vs1;
		hi1   = {3'b000, rd_ent.bg_average} + {1'b0, vabs1} + {3'b000, btol_q};
		lo1   = $signed({4'b0000, rd_ent.bg_average}) - $signed({2'b00, vabs1})
			- $signed({4'b0000, btol_q});
		bm1  = rd_ent.bg_present && (far1 || (hi1 > {3'b000, range_s1}
			&& lo1 < $signed({4'b0000, range_s1})));
		cls1 = mode_q == MODE_CLASSIFY && valid1;
		im1  = cls1 && inside1 && mm1;
		ib1  = cls1 && inside1 && use_bg_q && bm1;
		fg1  = cls1 && !im1 && !ib1;
	end

	// stage 3: background update
	logic [VAR_W-1:0]   qm3;
	logic [RANGE_W-1:0] avg3;
	logic [CNT_W-1:0]   cnt3;
	logic signed [17:0] sum3;

	always_comb begin
		qm3  = prod_s3[RECIP_SH +: VAR_W];
		avg3 = neg_s3 ? ent_s3.bg_average - qm3[RANGE_W-1:0]
			: ent_s3.bg_average + qm3[RANGE_W-1:0];
		cnt3 = (ent_s3.bg_count == CNT_W'(COUNT_MAX)) ? ent_s3.bg_count
			: ent_s3.bg_count + 1'b1;
		sum3 = $signed({2'b00, avg3}) - $signed({2'b00, range_s3})
			+ $signed({ent_s3.bg_variation[VAR_W-1], ent_s3.bg_variation});
		upd_ent = ent_s3;
		if (wm_s3) begin
			upd_ent.mask_present = 1'b1;
			upd_ent.mask_range   = range_s3;
		end
		if (wi_s3) begin
			upd_ent.bg_present   = 1'b1;
			upd_ent.bg_average   = range_s3;
			upd_ent.bg_count     = CNT_W'(1);
			upd_ent.bg_variation = '0;
		end
		if (wu_s3) begin
			upd_ent.bg_average   = avg3;
			upd_ent.bg_count     = cnt3;
			upd_ent.bg_variation = VAR_W'(sum3 >>> 1);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1)  v_s1 <= accept;
			if (rdy1) v_s2 <= v_s1;
			if (rdy2) v_s3 <= v_s2;
			if (rdy3) v_s4 <= v_s3;
		end
	end

	// write flags are control: cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_s2 <= 1'b0;
			wi_s2 <= 1'b0;
			wu_s2 <= 1'b0;
			wm_s3 <= 1'b0;
			wi_s3 <= 1'b0;
			wu_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				wm_s2 <= v_s1 && lm1;
				wi_s2 <= v_s1 && li1;
				wu_s2 <= v_s1 && lu1;
			end
			if (rdy2) begin
				wm_s3 <= v_s2 && wm_s2;
				wi_s3 <= v_s2 && wi_s2;
				wu_s3 <= v_s2 && wu_s2;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en1 && accept) begin
			beam_s1  <= beam_index;
			range_s1 <= range_mm;
		end
		if (rdy1) begin
			beam_s2  <= beam_s1;
			range_s2 <= range_s1;
			valid_s2 <= valid1;
			im_s2    <= im1;
			ib_s2    <= ib1;
			fg_s2    <= fg1;
			neg_s2   <= neg1;
			ent_s2   <= rd_ent;
			mq_s2    <= mq1;
			recip_s2 <= recip_tab[rd_ent.bg_count];
		end
		if (rdy2) begin
			beam_s3  <= beam_s2;
			range_s3 <= range_s2;
			valid_s3 <= valid_s2;
			im_s3    <= im_s2;
			ib_s3    <= ib_s2;
			fg_s3    <= fg_s2;
			neg_s3   <= neg_s2;
			ent_s3   <= ent_s2;
			prod_s3  <= mq_s2 * recip_s2;
		end
		if (rdy3) begin
			beam_s4  <= beam_s3;
			range_s4 <= range_s3;
			valid_s4 <= valid_s3;
			im_s4    <= im_s3;
			ib_s4    <= ib_s3;
			fg_s4    <= fg_s3;
		end
	end

	assign out_valid     = v_s4;
	assign index_out     = beam_s4;
	assign range_out     = range_s4;
	assign sample_valid  = valid_s4;
	assign in_mask       = im_s4;
	assign in_background = ib_s4;
	assign foreground    = fg_s4;
endmodule
`default_nettype wire

>>> rtl/core/lbf_checker.sv
// Port-level checks for the lidar beam background filter, bound to the top level.
`default_nettype none
module lbf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [15:0] range_out,
	input wire        sample_valid,
	input wire        in_mask,
	input wire        in_background,
	input wire        foreground
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(range_out) && $stable(foreground))
		else $error("output changed while stalled");

	a_fg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && foreground |-> sample_valid && !in_mask && !in_background)
		else $error("foreground with mask or background or invalid sample");

	a_flags_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (in_mask || in_background) |-> sample_valid)
		else $error("match flag on an invalid sample");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && in_stall)
		else $error("pipeline not empty or clearing not running after reset");
endmodule

bind lidar_beam_background_filter lbf_checker u_lbf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.range_out     (range_out),
	.sample_valid  (sample_valid),
	.in_mask       (in_mask),
	.in_background (in_background),
	.foreground    (foreground)
);
`default_nettype wire

>>> sim/tb_lidar_beam_background_filter.sv
// Self-checking testbench for the lidar beam background filter.
`default_nettype none
module tb_lidar_beam_background_filter;
	import lbf_pkg::*;

	typedef struct {
		logic [INDEX_W-1:0] beam;
		logic [RANGE_W-1:0] rng;
	} sample_t;

	typedef struct {
		logic [INDEX_W-1:0] beam;
		logic [RANGE_W-1:0] rng;
		logic               valid;
		logic               masked;
		logic               bg;
		logic               fg;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [INDEX_W-1:0] beam_index = '0;
	logic [RANGE_W-1:0] range_mm = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [INDEX_W-1:0] index_out;
	logic [RANGE_W-1:0] range_out;
	logic sample_valid, in_mask, in_background, foreground;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	lidar_beam_background_filter DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	mode_t       p_mode;
	int unsigned p_min, p_max, p_ltol, p_mtol, p_btol;
	bit          p_usebg;
	int unsigned m_range[BEAMS];
	bit          m_have[BEAMS];
	int unsigned b_avg[BEAMS];
	int unsigned b_cnt[BEAMS];
	int          b_var[BEAMS];
	bit          b_have[BEAMS];

	sample_t  pending[$];
	verdict_t expected[$];
	int  errors = 0;
	bit  no_idle = 0;
	bit  hold_in = 0;
	longint cycles = 0;

	function automatic int floor_half(int v);
		return (v >= 0) ? v / 2 : -((-v + 1) / 2);
	endfunction

	function automatic verdict_t filter_sample(sample_t s);
		verdict_t o;
		int unsigned b, r, cnt;
		int diff, v;
		b = s.beam;
		r = s.rng;
		o.beam = s.beam;
		o.rng = s.rng;
		o.valid = (r > p_min) && (r < p_max);
		o.masked = 0;
		o.bg = 0;
		o.fg = 0;
		if (o.valid && b < BEAMS) begin
			if (p_mode == MODE_LEARN_MASK) begin
				if (!m_have[b] || m_range[b] > r) begin
					m_range[b] = r;
					m_have[b] = 1;
				end
			end else if (p_mode == MODE_LEARN_BG) begin
				if (!b_have[b]) begin
					if (r < FAR_MM && r > NEAR_MM) begin
						b_avg[b] = r;
						b_cnt[b] = 1;
						b_var[b] = 0;
						b_have[b] = 1;
					end
				end else begin
					diff = int'(b_avg[b]) - int'(r);
					if (diff < 0) diff = -diff;
					if (!(r > FAR_MM || r < NEAR_MM || diff > int'(p_ltol))) begin
						cnt = b_cnt[b];
						b_avg[b] = ((b_avg[b] * cnt + r) / (cnt + 1)) & 16'hFFFF;
						b_cnt[b] = (cnt + 1 > COUNT_MAX) ? COUNT_MAX : cnt + 1;
						b_var[b] = floor_half(int'(b_avg[b]) - int'(r) + b_var[b]);
					end
				end
			end
		end
		if (o.valid && p_mode == MODE_CLASSIFY && b < BEAMS) begin
			if (m_have[b])
				o.masked = (r > FAR_MM) || (int'(m_range[b]) - int'(p_mtol) < int'(r));
			if (p_usebg && b_have[b]) begin
				v = (b_var[b] < 0) ? -b_var[b] : b_var[b];
				o.bg = (r > FAR_MM) ||
					((int'(b_avg[b]) + v + int'(p_btol) > int'(r)) &&
					 (int'(b_avg[b]) - v - int'(p_btol) < int'(r)));
			end
		end
		if (o.valid && p_mode == MODE_CLASSIFY)
			o.fg = !o.masked && !o.bg;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid)
				expected.insert(expected.size(), filter_sample('{beam_index, range_mm}));
			if (pending.size() > 0 && !hold_in && (no_idle || $urandom_range(99) >= 30)) begin
				sample_t s;
				s = pending.pop_front();
				beam_index <= s.beam;
				range_mm <= s.rng;
				in_valid <= 1;
			end else
				in_valid <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				verdict_t e;
				if (expected.size() == 0) begin
					$error("result with nothing expected: beam %0d", index_out);
					errors++;
				end else begin
					e = expected.pop_front();
					if (index_out !== e.beam) begin
						$error("index_out exp %0d got %0d", e.beam, index_out); errors++;
					end
					if (range_out !== e.rng) begin
						$error("range_out exp %0d got %0d", e.rng, range_out); errors++;
					end
					if (sample_valid !== e.valid) begin
						$error("sample_valid exp %0b got %0b", e.valid, sample_valid); errors++;
					end
					if (in_mask !== e.masked) begin
						$error("in_mask exp %0b got %0b", e.masked, in_mask); errors++;
					end
					if (in_background !== e.bg) begin
						$error("in_background exp %0b got %0b", e.bg, in_background); errors++;
					end
					if (foreground !== e.fg) begin
						$error("foreground exp %0b got %0b", e.fg, foreground); errors++;
					end
				end
			end
			out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 30);
		end
		if (cycles > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		case (idx)
			REG_MODE:      p_mode = mode_t'(val[1:0]);
			REG_RANGE_MIN: p_min = val & 16'hFFFF;
			REG_RANGE_MAX: p_max = val & 16'hFFFF;
			REG_LEARN_TOL: p_ltol = val & 16'hFFFF;
			REG_MASK_TOL:  p_mtol = val & 16'hFFFF;
			REG_BG_TOL:    p_btol = val & 16'hFFFF;
			REG_USE_BG:    p_usebg = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic push(int unsigned b, int unsigned r);
		sample_t s;
		s.beam = b[INDEX_W-1:0];
		s.rng = r[RANGE_W-1:0];
		pending.insert(pending.size(), s);
	endtask

	// beams 0..63 get most traffic so learned state is exercised
	function automatic int unsigned pick_beam();
		return ($urandom_range(9) < 8) ? $urandom_range(63) : $urandom_range(1023);
	endfunction

	function automatic int unsigned pick_range(int unsigned center);
		case ($urandom_range(9))
			0: return $urandom_range(65535);
			1: return $urandom_range(200);
			2: return 29700 + $urandom_range(200);
			default: return (center + $urandom_range(400) > 200) ?
				center + $urandom_range(400) - 200 : $urandom_range(400);
		endcase
	endfunction

	int unsigned center[64];

	initial begin
		p_mode = MODE_CLASSIFY; p_min = 0; p_max = 65535;
		p_ltol = 100; p_mtol = 100; p_btol = 100; p_usebg = 1;
		foreach (m_have[i]) begin
			m_have[i] = 0; b_have[i] = 0;
		end
		foreach (center[i]) center[i] = 300 + $urandom_range(29000);
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);

		// directed: classify with empty stores, extremes
		push(0, 0); push(1023, 65535); push(5, 1); push(6, 65534);
		drain();
		write_reg(REG_MODE, MODE_LEARN_MASK);
		push(0, 5000); push(0, 4000); push(0, 6000); push(1023, 29900); push(3, 65535);
		drain();
		write_reg(REG_MODE, MODE_LEARN_BG);
		write_reg(REG_LEARN_TOL, 0);
		push(1, 100); push(1, 29800); push(1, 1000); push(1, 1000); push(1, 1001);
		push(2, 29799); push(2, 29900);
		drain();
		write_reg(REG_MODE, MODE_UNUSED);
		push(7, 7000); push(8, 0);
		drain();
		write_reg(REG_MODE, MODE_CLASSIFY);
		push(0, 3950); push(0, 3850); push(1, 1000); push(1023, 30000); push(2, 29801);
		drain();

		// random phases: learn mask, learn bg, classify or unused mode, with varied settings
		for (int ph = 0; ph < 12; ph++) begin
			int unsigned m;
			m = ph % 4;
			write_reg(REG_MODE, (m == 3) ?
				(($urandom_range(3) == 0) ? MODE_UNUSED : MODE_CLASSIFY) : m);
			write_reg(REG_RANGE_MIN, (ph == 5) ? 65535 : ((ph % 3 == 0) ? 0 : $urandom_range(300)));
			write_reg(REG_RANGE_MAX, (ph == 7) ? 0 : ((ph % 3 == 1) ? 65535 :
				30000 + $urandom_range(35535)));
			write_reg(REG_LEARN_TOL, (ph == 1) ? 65535 : $urandom_range(300));
			write_reg(REG_MASK_TOL, (ph == 2) ? 65535 : ((ph == 6) ? 0 : $urandom_range(400)));
			write_reg(REG_BG_TOL, (ph == 3) ? 0 : ((ph == 10) ? 65535 : $urandom_range(400)));
			write_reg(REG_USE_BG, $urandom_range(1));
			write_reg(REG_NONE, $urandom);
			no_idle = (ph == 4);
			for (int k = 0; k < 150; k++) begin
				int unsigned b;
				b = pick_beam();
				push(b, pick_range(center[b % 64]));
				if (ph == 8 && k == 75) begin
					while (pending.size() > 0) @(posedge clk);
					hold_in = 1;
					while (in_valid || expected.size() > 0) @(posedge clk);
					hold_in = 0;
				end
			end
			drain();
		end

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
rtl/core/lbf_pkg.sv
rtl/core/lbf_beam_mem.sv
rtl/core/lidar_beam_background_filter.sv
rtl/core/lbf_checker.sv
sim/tb_lidar_beam_background_filter.sv
